FILE: src/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

  localparam int CHAN_W          = 8;
  localparam int HUE_W           = 12;
  localparam int SAT_W           = 13;
  localparam int DIVR_W          = 11;  // six times chroma needs 11 bits
  localparam int QUOT_BITS       = 12;  // quotient bits still to find after prep
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUOT_BITS / STEPS_PER_STAGE;
  localparam int PREP_STAGES     = 2;
  localparam int PIPE_STAGES     = PREP_STAGES + DIV_STAGES;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] value;
  } pix_out_t;

  // After the first stage: channels, value, chroma and the hue sector.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] chroma;
    sector_t           sector;
  } pre_t;

  // Running state of the two long divisions.
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] sat_rem;
    logic [SAT_W-1:0]  sat_q;
    logic [DIVR_W-1:0] hue_div;
    logic [DIVR_W-1:0] hue_rem;
    logic [HUE_W-1:0]  hue_q;
    logic              grey;
    logic              black;
  } div_t;

endpackage

FILE: src/rgbhsv_prep.sv
// Front two pipeline stages: extremes and sector, then hue numerator and divisor.
module rgbhsv_prep (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  rgbhsv_pkg::pix_in_t pix,
  output rgbhsv_pkg::div_t   div_o
);
  import rgbhsv_pkg::*;

  pre_t pre_nxt, pre_r;
  div_t div_nxt, div_r;

  logic [CHAN_W-1:0] mx_rg, mn_rg, mx, mn;
  logic [DIVR_W-1:0] c_ext, six_c, num;
  logic              sat_top;

  always_comb begin
    mx_rg = (pix.red > pix.green) ? pix.red : pix.green;
    mx    = (mx_rg > pix.blue) ? mx_rg : pix.blue;
    mn_rg = (pix.red < pix.green) ? pix.red : pix.green;
    mn    = (mn_rg < pix.blue) ? mn_rg : pix.blue;
    pre_nxt.red    = pix.red;
    pre_nxt.green  = pix.green;
    pre_nxt.blue   = pix.blue;
    pre_nxt.value  = mx;
    pre_nxt.chroma = mx - mn;
    // Ties go to red first, then green.
    if (mx == pix.red) begin
      pre_nxt.sector = SEC_RED;
    end else if (mx == pix.green) begin
      pre_nxt.sector = SEC_GREEN;
    end else begin
      pre_nxt.sector = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pre_r <= pre_nxt;
    end
  end

  always_comb begin
    c_ext = {{(DIVR_W-CHAN_W){1'b0}}, pre_r.chroma};
    six_c = (c_ext << 2) + (c_ext << 1);
    // The numerator lies in [0, six_c); intermediate wrap in 11 bits is harmless.
    unique case (pre_r.sector)
      SEC_RED: begin
        if (pre_r.green >= pre_r.blue) begin
          num = {{(DIVR_W-CHAN_W){1'b0}}, pre_r.green - pre_r.blue};
        end else begin
          num = six_c - {{(DIVR_W-CHAN_W){1'b0}}, pre_r.blue - pre_r.green};
        end
      end
      SEC_GREEN: begin
        num = (c_ext << 1) + {{(DIVR_W-CHAN_W){1'b0}}, pre_r.blue}
              - {{(DIVR_W-CHAN_W){1'b0}}, pre_r.red};
      end
      SEC_BLUE: begin
        num = (c_ext << 2) + {{(DIVR_W-CHAN_W){1'b0}}, pre_r.red}
              - {{(DIVR_W-CHAN_W){1'b0}}, pre_r.green};
      end
      default: begin
        num = '0;
      end
    endcase
    // Chroma never exceeds value, so the top saturation bit is set only when they match.
    sat_top         = (pre_r.chroma >= pre_r.value);
    div_nxt.value   = pre_r.value;
    div_nxt.sat_rem = sat_top ? (pre_r.chroma - pre_r.value) : pre_r.chroma;
    div_nxt.sat_q   = {{(SAT_W-1){1'b0}}, sat_top};
    div_nxt.hue_div = six_c;
    div_nxt.hue_rem = num;
    div_nxt.hue_q   = '0;
    div_nxt.grey    = (pre_r.chroma == '0);
    div_nxt.black   = (pre_r.value == '0);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: src/rgbhsv_div_stage.sv
// One pipeline stage of the saturation and hue restoring dividers.
module rgbhsv_div_stage (
  input  logic             clk,
  input  logic             en,
  input  rgbhsv_pkg::div_t div_i,
  output rgbhsv_pkg::div_t div_o
);
  import rgbhsv_pkg::*;

  div_t div_nxt, div_r;

  logic [CHAN_W:0] sat_t;
  logic [DIVR_W:0] hue_t;

  always_comb begin
    div_nxt = div_i;
    sat_t   = '0;
    hue_t   = '0;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      // Each step brings down one zero bit and tries the divisor once.
      sat_t = {div_nxt.sat_rem, 1'b0};
      if (sat_t >= {1'b0, div_nxt.value}) begin
        sat_t = sat_t - {1'b0, div_nxt.value};
        div_nxt.sat_q = {div_nxt.sat_q[SAT_W-2:0], 1'b1};
      end else begin
        div_nxt.sat_q = {div_nxt.sat_q[SAT_W-2:0], 1'b0};
      end
      div_nxt.sat_rem = sat_t[CHAN_W-1:0];

      hue_t = {div_nxt.hue_rem, 1'b0};
      if (hue_t >= {1'b0, div_nxt.hue_div}) begin
        hue_t = hue_t - {1'b0, div_nxt.hue_div};
        div_nxt.hue_q = {div_nxt.hue_q[HUE_W-2:0], 1'b1};
      end else begin
        div_nxt.hue_q = {div_nxt.hue_q[HUE_W-2:0], 1'b0};
      end
      div_nxt.hue_rem = hue_t[DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: src/rgb_to_hsv_pixel.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | pix_in_t  (red, green, blue)
//   out_    | output    | out_valid/out_stall | pix_out_t (hue, saturation, value)
//
// One pixel is taken every clock while the input is not stalled.
// The pipeline has two preparation stages plus six divider stages, two quotient bits each.
// Synchronous reset clears only the stage valid bits; no clearing pass is needed.
// A stall holds only the stages that are full, so bubbles are squeezed out and
// the input keeps moving while a finished result waits, until every stage is full.
module rgb_to_hsv_pixel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);
  import rgbhsv_pkg::*;

  logic [PIPE_STAGES-1:0] valid_r, valid_nxt;
  logic [PIPE_STAGES:0]   ready;
  div_t                   div_q [DIV_STAGES+1];

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    ready[PIPE_STAGES] = !out_stall;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid_r[i] || ready[i+1];
    end
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int i = 1; i < PIPE_STAGES; i++) begin
      if (ready[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  rgbhsv_prep u_prep (
    .clk   (clk),
    .en_a  (ready[0]),
    .en_b  (ready[1]),
    .pix   (in_data),
    .div_o (div_q[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rgbhsv_div_stage u_div (
      .clk   (clk),
      .en    (ready[PREP_STAGES+s]),
      .div_i (div_q[s]),
      .div_o (div_q[s+1])
    );
  end

  assign in_stall             = !ready[0];
  assign out_valid            = valid_r[PIPE_STAGES-1];
  assign out_data.hue         = div_q[DIV_STAGES].grey  ? '0 : div_q[DIV_STAGES].hue_q;
  assign out_data.saturation  = div_q[DIV_STAGES].black ? '0 : div_q[DIV_STAGES].sat_q;
  assign out_data.value       = div_q[DIV_STAGES].value;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted pixel did not enter the first stage");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input held although the output is free");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value == '0 |-> out_data.saturation == '0)
    else $error("black pixel with nonzero saturation");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.saturation <= 13'd4096)
    else $error("saturation beyond full scale");

endmodule
